// ===== design/sorted_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_macros.svh
// Assertion shorthands used by the queue checker. Each macro samples on
// the rising edge of clk and is switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication
`define SPQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types, sizes, codes and the key masking function of the sorted queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Queue size and name length
  localparam int DEPTH       = 16;
  localparam int NAME_BYTES  = 30;
  localparam int FIELD_BYTES = 30;
  localparam int NAME_LEN    = (NAME_BYTES < FIELD_BYTES) ? NAME_BYTES : FIELD_BYTES;
  localparam int NAME_W      = 8 * FIELD_BYTES;
  localparam int AGE_W       = 8;
  localparam int KEY_W       = AGE_W + NAME_W;
  localparam int ENTRY_W     = AGE_W + NAME_W;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // Operation codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  age;
    logic [63:0] name_0;
    logic [63:0] name_1;
    logic [63:0] name_2;
    logic [47:0] name_3;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       out_age;
    logic [63:0]      out_name_0;
    logic [63:0]      out_name_1;
    logic [63:0]      out_name_2;
    logic [47:0]      out_name_3;
    logic [CNT_W-1:0] entry_count;
    logic             has_entries;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       hold_cur;
    logic       wr_cur;
    logic       wr_new;
    logic       res_load;
    logic [1:0] res_code;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic full;
    logic k_one;
    logic greater;
    logic rsp_free;
  } dp_stat_t;

  // Zero every byte after the first zero byte and past the compare limit,
  // so that a plain unsigned compare orders names the way strcmp does.
  function automatic logic [NAME_W-1:0] mask_name(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] m;
    logic              live;
    m = '0;
    for (int i = 0; i < NAME_LEN; i++) begin
      live = 1'b1;
      for (int j = 0; j < i; j++) begin
        if (n[NAME_W-1-8*j -: 8] == 8'h00) live = 1'b0;
      end
      if (live) m[NAME_W-1-8*i -: 8] = n[NAME_W-1-8*i -: 8];
    end
    return m;
  endfunction

endpackage

// ===== design/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int DATA_W = 8,
  parameter int WORDS  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: entry RAM, fill count, shift pointer, key compare and the
// result register.
// ----------------------------------------------------------------------------
module spq_dp import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] k;
  logic [ADDR_W-1:0] raddr;
  logic [AGE_W-1:0]  new_age;
  logic [NAME_W-1:0] new_name;
  logic [KEY_W-1:0]  new_key;
  logic [AGE_W-1:0]  cur_age;
  logic [NAME_W-1:0] cur_name;
  logic [KEY_W-1:0]  cur_key;

  logic                we;
  logic [ENTRY_W-1:0]  wdata;
  logic [ENTRY_W-1:0]  rdata;
  logic [CNT_W-1:0]    count_after;
  logic                removed;

  // Entry store, one word per entry: age over name
  assign we    = cmd.wr_cur | cmd.wr_new;
  assign wdata = cmd.wr_new ? {new_age, new_name} : {cur_age, cur_name};

  spq_ram #(
    .DATA_W (ENTRY_W),
    .WORDS  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (k),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status back to the controller
  assign stat.count_zero = (count == '0);
  assign stat.full       = (count == CNT_W'(DEPTH));
  assign stat.k_one      = (k == ADDR_W'(1));
  assign stat.greater    = (cur_key > new_key);
  assign stat.rsp_free   = !rsp_valid || !rsp_stall;

  assign removed     = (cmd.res_code == ST_REMOVED);
  assign count_after = removed ? count - CNT_W'(1) : count;

  // Latch the request, pointers and compare keys
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_age  <= req.age;
      new_name <= {req.name_0, req.name_1, req.name_2, req.name_3};
      k        <= count[ADDR_W-1:0];
      raddr    <= ADDR_W'(count - CNT_W'(1));
    end
    if (cmd.hold_cur) begin
      cur_age  <= rdata[ENTRY_W-1 -: AGE_W];
      cur_name <= rdata[NAME_W-1:0];
      cur_key  <= {rdata[ENTRY_W-1 -: AGE_W], mask_name(rdata[NAME_W-1:0])};
      new_key  <= {new_age, mask_name(new_name)};
    end
    if (cmd.wr_cur) begin
      k     <= k - ADDR_W'(1);
      raddr <= k - ADDR_W'(2);
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_new) begin
      count <= count + CNT_W'(1);
    end else if (cmd.res_load && removed) begin
      count <= count - CNT_W'(1);
    end
  end

  // Result register: load a beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp.status      <= cmd.res_code;
      rsp.out_age     <= removed ? cur_age : '0;
      rsp.out_name_0  <= removed ? cur_name[NAME_W-1 -: 64] : '0;
      rsp.out_name_1  <= removed ? cur_name[NAME_W-65 -: 64] : '0;
      rsp.out_name_2  <= removed ? cur_name[NAME_W-129 -: 64] : '0;
      rsp.out_name_3  <= removed ? cur_name[47:0] : '0;
      rsp.entry_count <= count_after;
      rsp.has_entries <= (count_after != '0);
    end
  end

endmodule

// ===== design/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: takes one request, walks the insert shift from the tail,
// or fetches the tail for a remove, then posts the result beat.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_cmd,
  output logic     req_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LATCH,
    S_COMPARE,
    S_PLACE,
    S_REPORT
  } state_t;

  state_t     state;
  state_t     state_next;
  logic       op_remove;
  logic       op_remove_next;
  logic [1:0] code;
  logic [1:0] code_next;

  assign req_stall = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next     = state;
    op_remove_next = op_remove;
    code_next      = code;
    cmd            = '0;
    cmd.res_code   = code;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept     = 1'b1;
          op_remove_next = (req_cmd == CMD_REMOVE);
          if (req_cmd == CMD_INSERT) begin
            code_next = ST_INSERTED;
            if (stat.full) begin
              code_next  = ST_FULL;
              state_next = S_REPORT;
            end else if (stat.count_zero) begin
              state_next = S_PLACE;
            end else begin
              state_next = S_READ;
            end
          end else begin
            if (stat.count_zero) begin
              code_next  = ST_EMPTY;
              state_next = S_REPORT;
            end else begin
              code_next  = ST_REMOVED;
              state_next = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.hold_cur = 1'b1;
        state_next   = op_remove ? S_REPORT : S_COMPARE;
      end
      S_COMPARE: begin
        // Shift the greater entry up one slot, or drop the new one in here
        if (stat.greater) begin
          cmd.wr_cur = 1'b1;
          state_next = stat.k_one ? S_PLACE : S_READ;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = S_REPORT;
        end
      end
      S_PLACE: begin
        cmd.wr_new = 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (stat.rsp_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and held operation
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op_remove <= 1'b0;
      code      <= ST_INSERTED;
    end else begin
      state     <= state_next;
      op_remove <= op_remove_next;
      code      <= code_next;
    end
  end

endmodule

// ===== design/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in ascending key order (age, then name).
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_valid / req_stall / req carries one operation per
//   beat: insert an entry (age and 30-byte name) or remove the greatest one.
//   Response channel rsp_valid / rsp_stall / rsp returns exactly one beat per
//   request: status, the removed entry (zero otherwise), the entry count
//   and a non-empty flag.
//   One request is worked at a time; req_stall is high from the accept
//   until the result is posted to the response register.
//   The insert walks from the tail through the entry RAM, one read and one
//   write per step; each step passes through the read, latch and compare states.
//   The next request is taken the cycle after the result is posted, even
//   while that beat still waits under rsp_stall; a second result waits in
//   the controller until the response register is free.
//   Reset empties the queue and clears the response valid; RAM contents
//   are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== design/spq_check.sv =====
// ----------------------------------------------------------------------------
// spq_check
// Port-level checker for the sorted queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module spq_check import spq_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input out_item_t rsp
);

  // Stalled response beat holds
  `SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // An accepted request keeps the queue busy the next cycle
  `SPQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

  // Full is only reported with every slot taken
  `SPQ_ASSERT_SAME(a_full_count, rsp_valid && rsp.status == ST_FULL,
    rsp.entry_count == CNT_W'(DEPTH))

  // Empty report carries a zero count, a clear non-empty flag and a zero age
  `SPQ_ASSERT_SAME(a_empty_count, rsp_valid && rsp.status == ST_EMPTY,
    rsp.entry_count == '0 && !rsp.has_entries && rsp.out_age == '0)

  // Non-empty flag tracks the count
  `SPQ_ASSERT_SAME(a_has_entries, rsp_valid, rsp.has_entries == (rsp.entry_count != '0))

endmodule

bind sorted_priority_queue spq_check u_check (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue. A queue of operations
// (directed corner cases, then random runs that lean toward insert or remove
// so the list sweeps between empty and full) feeds a clocked driver. Each
// accepted request beat updates a local copy of the sorted list, and the
// expected response is queued. A clocked monitor stalls at random and
// compares every response beat field by field against the oldest expected.
// ----------------------------------------------------------------------------
module tb_top;
  import spq_pkg::*;

  localparam int RAND_OPS    = 1200;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN       = 120;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  in_item_t  req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  out_item_t rsp;

  // Operations waiting to be sent, responses owed by the queue
  in_item_t  ops_todo[$];
  out_item_t results_due[$];
  int        mismatches = 0;

  // Local copy of the sorted list
  logic [7:0]        list_age[DEPTH];
  logic [NAME_W-1:0] list_name[DEPTH];
  int                list_count = 0;

  int          tx_gap  = 0;
  int          rx_hold = 0;
  int unsigned cyc     = 0;

  sorted_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Compare names byte by byte, stopping at the first shared zero byte
  function automatic int name_order(input logic [NAME_W-1:0] a, input logic [NAME_W-1:0] b);
    logic [7:0] x;
    logic [7:0] y;
    for (int i = 0; i < NAME_LEN; i++) begin
      x = a[NAME_W-1-8*i -: 8];
      y = b[NAME_W-1-8*i -: 8];
      if (x != y) return (x < y) ? -1 : 1;
      if (x == 8'h00) return 0;
    end
    return 0;
  endfunction

  function automatic bit key_le(input logic [7:0] a_age, input logic [NAME_W-1:0] a_name,
                                input logic [7:0] b_age, input logic [NAME_W-1:0] b_name);
    if (a_age != b_age) return a_age < b_age;
    return name_order(a_name, b_name) <= 0;
  endfunction

  // Apply one operation to the local list and return the response it owes
  function automatic out_item_t sorted_update(input in_item_t op);
    out_item_t         r;
    logic [NAME_W-1:0] nm;
    int                pos;
    r   = '0;
    nm  = {op.name_0, op.name_1, op.name_2, op.name_3};
    pos = 0;
    if (op.cmd == CMD_INSERT) begin
      if (list_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        while (pos < list_count && key_le(list_age[pos], list_name[pos], op.age, nm)) pos++;
        for (int k = list_count; k > pos; k--) begin
          list_age[k]  = list_age[k-1];
          list_name[k] = list_name[k-1];
        end
        list_age[pos]  = op.age;
        list_name[pos] = nm;
        list_count++;
        r.status = ST_INSERTED;
      end
    end else begin
      if (list_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        list_count--;
        r.status  = ST_REMOVED;
        r.out_age = list_age[list_count];
        {r.out_name_0, r.out_name_1, r.out_name_2, r.out_name_3} = list_name[list_count];
      end
    end
    r.entry_count = CNT_W'(list_count);
    r.has_entries = (list_count != 0);
    return r;
  endfunction

  function automatic in_item_t make_op(input logic c, input logic [7:0] a,
                                       input logic [NAME_W-1:0] n);
    in_item_t op;
    op.cmd = c;
    op.age = a;
    {op.name_0, op.name_1, op.name_2, op.name_3} = n;
    return op;
  endfunction

  function automatic logic [NAME_W-1:0] text_name(input string s);
    logic [NAME_W-1:0] n;
    n = '0;
    for (int i = 0; i < s.len() && i < FIELD_BYTES; i++) n[NAME_W-1-8*i -: 8] = s[i];
    return n;
  endfunction

  // Mostly short names over a tiny alphabet so keys tie often; some long or
  // unterminated names, some with junk past the terminator, some pure noise
  function automatic logic [NAME_W-1:0] rand_name();
    logic [NAME_W-1:0] n;
    int                style;
    int                len;
    n     = '0;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      for (int i = 0; i < FIELD_BYTES; i++) n[NAME_W-1-8*i -: 8] = 8'($urandom_range(0, 255));
      return n;
    end
    len = (style < 7) ? $urandom_range(0, 4) : $urandom_range(0, FIELD_BYTES);
    for (int i = 0; i < FIELD_BYTES; i++) begin
      if (i < len)
        n[NAME_W-1-8*i -: 8] = (style < 5) ? 8'(8'h61 + $urandom_range(0, 2))
                                           : 8'($urandom_range(1, 255));
      else if (i > len && style[0])
        n[NAME_W-1-8*i -: 8] = 8'($urandom_range(0, 255));
    end
    return n;
  endfunction

  function automatic logic [7:0] rand_age();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(20, 22));
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", fname, want, got);
      mismatches++;
    end
  endtask

  // Driver: predict on each accepted beat, then present the next one
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      tx_gap    <= 0;
    end else begin
      if (req_valid && !req_stall) results_due.push_back(sorted_update(req));
      if (!req_valid || !req_stall) begin
        if (tx_gap > 0) begin
          tx_gap    <= tx_gap - 1;
          req_valid <= 1'b0;
        end else if (ops_todo.size() > 0) begin
          req       <= ops_todo.pop_front();
          req_valid <= 1'b1;
          tx_gap    <= ((cyc % 600) < 150) ? 0 : idle_len();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted response beat, stall at random
  always @(posedge clk) begin : rx_side
    int        n;
    out_item_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      rx_hold   <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (results_due.size() == 0) begin
          $error("response beat with nothing expected: status %0d", rsp.status);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("out_age", 64'(want.out_age), 64'(rsp.out_age));
          check_field("out_name_0", want.out_name_0, rsp.out_name_0);
          check_field("out_name_1", want.out_name_1, rsp.out_name_1);
          check_field("out_name_2", want.out_name_2, rsp.out_name_2);
          check_field("out_name_3", 64'(want.out_name_3), 64'(rsp.out_name_3));
          check_field("entry_count", 64'(want.entry_count), 64'(rsp.entry_count));
          check_field("has_entries", 64'(want.has_entries), 64'(rsp.has_entries));
        end
      end
      if (rx_hold > 0) begin
        rsp_stall <= 1'b1;
        rx_hold   <= rx_hold - 1;
      end else begin
        n = (((cyc + 300) % 600) < 150) ? 0 : idle_len();
        rsp_stall <= (n > 0);
        rx_hold   <= (n > 0) ? n - 1 : 0;
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst === 1'b0);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [NAME_W-1:0] nm;
    int                sent;
    int                run;
    int                lean;
    int                r;
    bit                ins;

    // Remove from an empty queue
    ops_todo.push_back(make_op(CMD_REMOVE, rand_age(), rand_name()));
    // Smallest and largest keys, then a duplicate of the largest
    ops_todo.push_back(make_op(CMD_INSERT, 8'd0, '0));
    ops_todo.push_back(make_op(CMD_INSERT, 8'd255, '1));
    ops_todo.push_back(make_op(CMD_INSERT, 8'd255, '1));
    // Same age, order by name; junk past the terminator ties with plain "bob"
    ops_todo.push_back(make_op(CMD_INSERT, 8'd100, text_name("bob")));
    ops_todo.push_back(make_op(CMD_INSERT, 8'd100, text_name("alice")));
    nm = text_name("bob");
    nm[NAME_W-1-8*5 -: 8] = 8'hA5;
    nm[7:0] = 8'h3C;
    ops_todo.push_back(make_op(CMD_INSERT, 8'd100, nm));
    ops_todo.push_back(make_op(CMD_INSERT, 8'd100, text_name("bobby")));
    // Unterminated names that differ only in the last byte
    ops_todo.push_back(make_op(CMD_INSERT, 8'd100, text_name("aaaaaaaaaaaaaaaaaaaaaaaaaaaaab")));
    ops_todo.push_back(make_op(CMD_INSERT, 8'd100, text_name("aaaaaaaaaaaaaaaaaaaaaaaaaaaaaa")));
    // High bytes compare as unsigned
    nm = '0;
    nm[NAME_W-1 -: 8] = 8'h80;
    ops_todo.push_back(make_op(CMD_INSERT, 8'd50, nm));
    nm[NAME_W-1 -: 8] = 8'h7F;
    ops_todo.push_back(make_op(CMD_INSERT, 8'd50, nm));
    // Drain everything and remove once more on empty
    for (int i = 0; i < 12; i++) ops_todo.push_back(make_op(CMD_REMOVE, rand_age(), rand_name()));

    // Random runs leaning to insert, to remove, or balanced
    sent = 0;
    while (sent < RAND_OPS) begin
      run  = $urandom_range(20, 60);
      lean = $urandom_range(0, 2);
      for (int i = 0; i < run; i++) begin
        r   = $urandom_range(0, 99);
        ins = (lean == 0) ? (r < 85) : (lean == 1) ? (r < 15) : (r < 50);
        ops_todo.push_back(make_op(ins ? CMD_INSERT : CMD_REMOVE, rand_age(), rand_name()));
      end
      sent += run;
    end

    // Hold reset, then release it once
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for every beat to go out and every response to come back
    do @(posedge clk);
    while (ops_todo.size() != 0 || req_valid || results_due.size() != 0);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0 && results_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
